FILE: rtl/fgn_pkg.sv
`timescale 1ns / 1ps

package fgn_pkg;

   // Sizing
   localparam int MAX_OCTAVES  = 16;
   localparam int PERM_ENTRIES = 256;
   localparam int PERM_AW      = $clog2(PERM_ENTRIES);
   localparam int OCT_W        = $clog2(MAX_OCTAVES + 1);

   // |n * amp| < 2^47 per octave, so the weighted sum needs this many magnitude bits
   localparam int DIV_W   = 47 + $clog2(MAX_OCTAVES);
   localparam int TOTAL_W = DIV_W + 1;
   localparam int ASUM_W  = 32 + $clog2(MAX_OCTAVES);
   localparam int DCNT_W  = $clog2(DIV_W);

   // Shared multiplier
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // Fixed point
   localparam int FR_W    = 16;
   localparam int FADE_W  = 17;
   localparam int GRAD_W  = 19;
   localparam int LERP_W  = 20;
   localparam int COORD_W = 18;

   // Request opcodes
   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // CSR map
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] REG_BASE_FREQ   = 3'd0;
   localparam logic [CSR_AW-1:0] REG_OCT_COUNT   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_AMP_FACTOR  = 3'd2;
   localparam logic [CSR_AW-1:0] REG_FREQ_FACTOR = 3'd3;
   localparam logic [CSR_AW-1:0] REG_HEIGHT_LOW  = 3'd4;
   localparam logic [CSR_AW-1:0] REG_HEIGHT_HIGH = 3'd5;

   // Improved-noise gradient select: dot product with the cube edge vector that the hash h picks
   function automatic logic signed [GRAD_W-1:0] grad(
      input logic [3:0]                 h,
      input logic signed [COORD_W-1:0]  x,
      input logic signed [COORD_W-1:0]  y,
      input logic signed [COORD_W-1:0]  z
   );
      logic signed [GRAD_W-1:0] u;
      logic signed [GRAD_W-1:0] v;
      u = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
      if (h < 4'd4) begin
         v = GRAD_W'(y);
      end else if (h == 4'd12 || h == 4'd14) begin
         v = GRAD_W'(x);
      end else begin
         v = GRAD_W'(z);
      end
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

endpackage

FILE: rtl/fgn_perm_mem.sv
`timescale 1ns / 1ps

// Permutation table: 256x8 synchronous RAM with a registered read.
// Entries never written read back as their own index.
module fgn_perm_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [fgn_pkg::PERM_AW-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic [fgn_pkg::PERM_AW-1:0] rd_addr,
   output logic [7:0]                  rd_data
);

   logic [7:0]                        mem [fgn_pkg::PERM_ENTRIES];
   logic [fgn_pkg::PERM_ENTRIES-1:0]  valid_ff;
   logic [7:0]                        q_ff;
   logic                              q_valid_ff;
   logic [fgn_pkg::PERM_AW-1:0]       q_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff      <= mem[rd_addr];
      q_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         q_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = q_valid_ff ? q_ff : 8'(q_addr_ff);

endmodule

FILE: rtl/fgn_mult.sv
`timescale 1ns / 1ps

// Shared signed multiplier, product registered.
module fgn_mult (
   input  logic                               clock,
   input  logic signed [fgn_pkg::MUL_W-1:0]   op_a,
   input  logic signed [fgn_pkg::MUL_W-1:0]   op_b,
   output logic signed [fgn_pkg::PROD_W-1:0]  prod
);

   logic signed [fgn_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/fgn_div.sv
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
module fgn_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fgn_pkg::DIV_W-1:0]    dividend,
   input  logic [fgn_pkg::ASUM_W-1:0]   divisor,
   output logic                         done,
   output logic [fgn_pkg::DIV_W-1:0]    quotient
);

   logic [fgn_pkg::DIV_W-1:0]   quo_ff;
   logic [fgn_pkg::ASUM_W-1:0]  rem_ff;
   logic [fgn_pkg::ASUM_W-1:0]  den_ff;
   logic [fgn_pkg::DCNT_W-1:0]  cnt_ff;
   logic                        run_ff;
   logic                        done_ff;
   logic [fgn_pkg::ASUM_W:0]    rem_sh;
   logic [fgn_pkg::ASUM_W:0]    rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[fgn_pkg::DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff <= dividend;
            den_ff <= divisor;
            rem_ff <= '0;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (!rem_sub[fgn_pkg::ASUM_W]) begin
               rem_ff <= rem_sub[fgn_pkg::ASUM_W-1:0];
               quo_ff <= {quo_ff[fgn_pkg::DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[fgn_pkg::ASUM_W-1:0];
               quo_ff <= {quo_ff[fgn_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == fgn_pkg::DCNT_W'(fgn_pkg::DIV_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/fractal_gradient_noise_unit.sv
`timescale 1ns / 1ps

// Fractal gradient noise unit. Pulse start with req_opcode = 0 and a position
// while busy is low; the unit sums improved gradient noise over the configured
// octaves and returns one height on rsp_height with a one-cycle rsp_valid
// strobe. The receiver cannot stall: capture the result in that cycle.
// req_opcode = 1 loads one permutation entry and gives no result; busy stays
// low. Each octave runs on one shared 34x34 multiplier and the permutation
// RAM's single read port: the three fade curves, fourteen table reads, seven
// blends, then accumulate and frequency/amplitude update. A restoring divide
// (load, 51 quotient bits, finish) and a height map follow the last octave;
// with zero octaves the unit goes straight to the height map.
// The permutation table reads back as the identity after reset with no
// clearing pass. CSR writes (csr_ready is always high) must only be issued
// while busy is low.
module fractal_gradient_noise_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic signed [31:0]                   req_pos_x,
   input  logic signed [31:0]                   req_pos_y,
   input  logic signed [31:0]                   req_pos_z,
   input  logic [7:0]                           req_table_index,
   input  logic [7:0]                           req_table_value,
   output logic                                 rsp_valid,
   output logic signed [31:0]                   rsp_height,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fgn_pkg::CSR_AW-1:0]           csr_index,
   input  logic [31:0]                          csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_POS, ST_SQR, ST_CUBE, ST_POLY, ST_FADE,
      ST_HASH, ST_GRAD, ST_LERP_ISSUE, ST_LERP_TAKE,
      ST_ACC_MUL, ST_ACC_SUM, ST_AMP, ST_FREQ,
      ST_DIV, ST_DIV_WAIT, ST_HEIGHT_MUL, ST_HEIGHT_TAKE
   } state_type;

   // ---------------- CSRs ----------------
   logic [31:0]        base_freq_ff;
   logic [4:0]         oct_count_ff;
   logic [19:0]        amp_factor_ff;
   logic [19:0]        freq_factor_ff;
   logic signed [31:0] height_low_ff;
   logic signed [31:0] height_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_freq_ff   <= 32'd16777216;
         oct_count_ff   <= 5'd1;
         amp_factor_ff  <= 20'd32768;
         freq_factor_ff <= 20'd131072;
         height_low_ff  <= -32'sd10000;
         height_high_ff <= 32'sd10000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fgn_pkg::REG_BASE_FREQ:   base_freq_ff   <= csr_wdata;
            fgn_pkg::REG_OCT_COUNT:   oct_count_ff   <= csr_wdata[4:0];
            fgn_pkg::REG_AMP_FACTOR:  amp_factor_ff  <= csr_wdata[19:0];
            fgn_pkg::REG_FREQ_FACTOR: freq_factor_ff <= csr_wdata[19:0];
            fgn_pkg::REG_HEIGHT_LOW:  height_low_ff  <= $signed(csr_wdata);
            fgn_pkg::REG_HEIGHT_HIGH: height_high_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------- datapath state ----------------
   state_type                          state_ff;
   logic [3:0]                         step_ff;
   logic [fgn_pkg::OCT_W-1:0]          oct_left_ff;
   logic [31:0]                        pos_ff [3];
   logic [31:0]                        freq_ff;
   logic [31:0]                        amp_ff;
   logic [fgn_pkg::ASUM_W-1:0]         amp_sum_ff;
   logic signed [fgn_pkg::TOTAL_W-1:0] total_ff;
   logic [7:0]                         cell_ff [3];
   logic [fgn_pkg::FR_W-1:0]           fr_ff [3];
   logic [31:0]                        sq_ff;
   logic [fgn_pkg::FADE_W-1:0]         fade_ff [3];
   logic [7:0]                         a_ff, b_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic [3:0]                         hash_ff [8];
   logic signed [fgn_pkg::LERP_W-1:0]  lerp_ff [7];
   logic signed [fgn_pkg::LERP_W-1:0]  la_ff;
   logic signed [15:0]                 n_ff;
   logic                               rsp_valid_ff;
   logic signed [31:0]                 rsp_height_ff;

   logic [1:0]                         axis;
   logic                               accept;
   logic [fgn_pkg::OCT_W-1:0]          oct_start;

   // shared units
   logic signed [fgn_pkg::MUL_W-1:0]   mul_a_in, mul_b_in;
   logic signed [fgn_pkg::PROD_W-1:0]  prod;
   logic [fgn_pkg::PERM_AW-1:0]        rd_addr;
   logic [7:0]                         rd_data;
   logic                               div_start;
   logic                               div_done;
   logic [fgn_pkg::DIV_W-1:0]          div_dividend;
   logic [fgn_pkg::DIV_W-1:0]          div_q;

   assign axis   = step_ff[1:0];
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign oct_start = (int'(oct_count_ff) > fgn_pkg::MAX_OCTAVES)
                      ? fgn_pkg::OCT_W'(fgn_pkg::MAX_OCTAVES)
                      : fgn_pkg::OCT_W'(oct_count_ff);

   fgn_perm_mem u_perm (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_opcode == fgn_pkg::OP_WRITE),
      .wr_addr (req_table_index),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fgn_mult u_mult (
      .clock (clock),
      .op_a  (mul_a_in),
      .op_b  (mul_b_in),
      .prod  (prod)
   );

   fgn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (amp_sum_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- combinational helpers ----------------
   // fade polynomial 6t^2 - 15t + 10 in Q16, t^2 taken from sq_ff
   logic [34:0] six_sq;
   logic [21:0] poly;
   assign six_sq = {1'b0, sq_ff, 2'b00} + {2'b00, sq_ff, 1'b0};
   assign poly   = 22'(six_sq[34:16]) + 22'd655360 - {2'b00, fr_ff[axis], 4'b0000}
                   + 22'(fr_ff[axis]);

   // corner gradients; corner bit0 = x+1, bit1 = y+1, bit2 = z+1
   logic signed [fgn_pkg::COORD_W-1:0] x0, y0, z0, x1, y1, z1;
   logic signed [fgn_pkg::GRAD_W-1:0]  g [8];
   assign x0 = $signed({2'b00, fr_ff[0]});
   assign y0 = $signed({2'b00, fr_ff[1]});
   assign z0 = $signed({2'b00, fr_ff[2]});
   assign x1 = x0 - 18'sd65536;
   assign y1 = y0 - 18'sd65536;
   assign z1 = z0 - 18'sd65536;

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         g[c] = fgn_pkg::grad(hash_ff[c],
                              c[0] ? x1 : x0,
                              c[1] ? y1 : y0,
                              c[2] ? z1 : z0);
      end
   end

   // blend operand select
   logic [fgn_pkg::FADE_W-1:0]        lerp_t;
   logic signed [fgn_pkg::LERP_W-1:0] lerp_a, lerp_b;
   logic signed [fgn_pkg::LERP_W:0]   lerp_d;

   always_comb begin
      case (step_ff[2:0])
         3'd0: begin
            lerp_t = fade_ff[0]; lerp_a = fgn_pkg::LERP_W'(g[0]);
            lerp_b = fgn_pkg::LERP_W'(g[1]);
         end
         3'd1: begin
            lerp_t = fade_ff[0]; lerp_a = fgn_pkg::LERP_W'(g[2]);
            lerp_b = fgn_pkg::LERP_W'(g[3]);
         end
         3'd2: begin
            lerp_t = fade_ff[1]; lerp_a = lerp_ff[0]; lerp_b = lerp_ff[1];
         end
         3'd3: begin
            lerp_t = fade_ff[0]; lerp_a = fgn_pkg::LERP_W'(g[4]);
            lerp_b = fgn_pkg::LERP_W'(g[5]);
         end
         3'd4: begin
            lerp_t = fade_ff[0]; lerp_a = fgn_pkg::LERP_W'(g[6]);
            lerp_b = fgn_pkg::LERP_W'(g[7]);
         end
         3'd5: begin
            lerp_t = fade_ff[1]; lerp_a = lerp_ff[3]; lerp_b = lerp_ff[4];
         end
         3'd6: begin
            lerp_t = fade_ff[2]; lerp_a = lerp_ff[2]; lerp_b = lerp_ff[5];
         end
         default: begin
            lerp_t = '0; lerp_a = '0; lerp_b = '0;
         end
      endcase
   end

   assign lerp_d = (fgn_pkg::LERP_W+1)'(lerp_b) - (fgn_pkg::LERP_W+1)'(lerp_a);

   // octave noise: floor half of the final blend, clamped to Q1.15
   logic signed [fgn_pkg::LERP_W-1:0] half;
   logic signed [15:0]                oct_n;
   assign half = lerp_ff[6] >>> 1;
   always_comb begin
      if (half > 20'sd32767)       oct_n = 16'sh7FFF;
      else if (half < -20'sd32768) oct_n = -16'sh8000;
      else                          oct_n = half[15:0];
   end

   // divide by amplitude sum, sign and magnitude around the unsigned divider
   logic                               tot_neg;
   logic signed [fgn_pkg::TOTAL_W-1:0] tot_abs;
   logic signed [15:0]                 div_n;
   assign tot_neg      = total_ff[fgn_pkg::TOTAL_W-1];
   assign tot_abs      = tot_neg ? -total_ff : total_ff;
   assign div_dividend = tot_abs[fgn_pkg::DIV_W-1:0];
   assign div_start    = (state_ff == ST_DIV);

   always_comb begin
      if (tot_neg) begin
         if (div_q > fgn_pkg::DIV_W'(32768)) div_n = -16'sh8000;
         else                                 div_n = -$signed(div_q[15:0]);
      end else begin
         if (div_q > fgn_pkg::DIV_W'(32767)) div_n = 16'sh7FFF;
         else                                 div_n = $signed(div_q[15:0]);
      end
   end

   // height map
   logic signed [32:0] h_diff;
   logic signed [34:0] h_sum;
   logic signed [31:0] h_sat;
   assign h_diff = 33'(height_high_ff) - 33'(height_low_ff);
   assign h_sum  = 35'(height_low_ff) + $signed(prod[50:16]);
   always_comb begin
      if (h_sum > 35'sd2147483647)        h_sat = 32'sh7FFFFFFF;
      else if (h_sum < -35'sd2147483648)  h_sat = 32'sh80000000;
      else                                h_sat = h_sum[31:0];
   end

   // per-octave scale updates, saturating Q.16 products
   logic [31:0] prod_sat;
   assign prod_sat = (|prod[fgn_pkg::PROD_W-1:48]) ? 32'hFFFFFFFF : prod[47:16];

   // ---------------- multiplier and RAM address steering ----------------
   always_comb begin
      mul_a_in = '0;
      mul_b_in = '0;
      rd_addr  = '0;
      case (state_ff)
         ST_POS: begin
            mul_a_in = $signed({2'b00, pos_ff[axis]});
            mul_b_in = $signed({2'b00, freq_ff});
         end
         ST_SQR: begin
            mul_a_in = $signed(34'(prod[23:8]));
            mul_b_in = $signed(34'(prod[23:8]));
         end
         ST_CUBE: begin
            mul_a_in = $signed(34'(prod[31:0]));
            mul_b_in = $signed(34'(fr_ff[axis]));
         end
         ST_POLY: begin
            mul_a_in = $signed(34'(prod[47:32]));
            mul_b_in = $signed(34'(poly));
         end
         ST_HASH: begin
            case (step_ff[2:0])
               3'd0:    rd_addr = cell_ff[0];
               3'd1:    rd_addr = cell_ff[0] + 8'd1;
               3'd2:    rd_addr = a_ff;
               3'd3:    rd_addr = a_ff + 8'd1;
               3'd4:    rd_addr = b_ff;
               3'd5:    rd_addr = b_ff + 8'd1;
               default: rd_addr = '0;
            endcase
         end
         ST_GRAD: begin
            case (step_ff[1:0])
               2'd0:    rd_addr = aa_ff + 8'(step_ff[2]);
               2'd1:    rd_addr = ba_ff + 8'(step_ff[2]);
               2'd2:    rd_addr = ab_ff + 8'(step_ff[2]);
               default: rd_addr = bb_ff + 8'(step_ff[2]);
            endcase
         end
         ST_LERP_ISSUE: begin
            mul_a_in = 34'(lerp_d);
            mul_b_in = $signed(34'(lerp_t));
         end
         ST_ACC_MUL: begin
            mul_a_in = 34'(oct_n);
            mul_b_in = $signed({2'b00, amp_ff});
         end
         ST_ACC_SUM: begin
            mul_a_in = $signed({2'b00, amp_ff});
            mul_b_in = $signed(34'(amp_factor_ff));
         end
         ST_AMP: begin
            mul_a_in = $signed({2'b00, freq_ff});
            mul_b_in = $signed(34'(freq_factor_ff));
         end
         ST_HEIGHT_MUL: begin
            mul_a_in = $signed(34'({~n_ff[15], n_ff[14:0]}));
            mul_b_in = 34'(h_diff);
         end
         default: ;
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         oct_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_opcode == fgn_pkg::OP_EVAL) begin
                  pos_ff[0]   <= req_pos_x;
                  pos_ff[1]   <= req_pos_y;
                  pos_ff[2]   <= req_pos_z;
                  freq_ff     <= base_freq_ff;
                  amp_ff      <= 32'd65536;
                  amp_sum_ff  <= '0;
                  total_ff    <= '0;
                  oct_left_ff <= oct_start;
                  step_ff     <= '0;
                  n_ff        <= '0;
                  state_ff    <= (oct_start == '0) ? ST_HEIGHT_MUL : ST_POS;
               end
            end
            ST_POS: state_ff <= ST_SQR;
            ST_SQR: begin
               cell_ff[axis] <= prod[31:24];
               fr_ff[axis]   <= prod[23:8];
               state_ff      <= ST_CUBE;
            end
            ST_CUBE: begin
               sq_ff    <= prod[31:0];
               state_ff <= ST_POLY;
            end
            ST_POLY: state_ff <= ST_FADE;
            ST_FADE: begin
               fade_ff[axis] <= prod[32:16];
               if (axis == 2'd2) begin
                  step_ff  <= '0;
                  state_ff <= ST_HASH;
               end else begin
                  step_ff  <= step_ff + 4'd1;
                  state_ff <= ST_POS;
               end
            end
            // read data arrives in the cycle after its address is driven
            ST_HASH: begin
               case (step_ff[2:0])
                  3'd1:    a_ff  <= rd_data + cell_ff[1];
                  3'd2:    b_ff  <= rd_data + cell_ff[1];
                  3'd3:    aa_ff <= rd_data + cell_ff[2];
                  3'd4:    ab_ff <= rd_data + cell_ff[2];
                  3'd5:    ba_ff <= rd_data + cell_ff[2];
                  3'd6:    bb_ff <= rd_data + cell_ff[2];
                  default: ;
               endcase
               if (step_ff == 4'd6) begin
                  step_ff  <= '0;
                  state_ff <= ST_GRAD;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_GRAD: begin
               if (step_ff != 4'd0) hash_ff[3'(step_ff - 4'd1)] <= rd_data[3:0];
               if (step_ff == 4'd8) begin
                  step_ff  <= '0;
                  state_ff <= ST_LERP_ISSUE;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_LERP_ISSUE: begin
               la_ff    <= lerp_a;
               state_ff <= ST_LERP_TAKE;
            end
            ST_LERP_TAKE: begin
               lerp_ff[step_ff[2:0]] <= la_ff + $signed(prod[35:16]);
               if (step_ff == 4'd6) begin
                  state_ff <= ST_ACC_MUL;
               end else begin
                  step_ff  <= step_ff + 4'd1;
                  state_ff <= ST_LERP_ISSUE;
               end
            end
            ST_ACC_MUL: state_ff <= ST_ACC_SUM;
            ST_ACC_SUM: begin
               total_ff   <= total_ff + $signed(prod[fgn_pkg::TOTAL_W-1:0]);
               amp_sum_ff <= amp_sum_ff + fgn_pkg::ASUM_W'(amp_ff);
               state_ff   <= ST_AMP;
            end
            ST_AMP: begin
               amp_ff   <= prod_sat;
               state_ff <= ST_FREQ;
            end
            ST_FREQ: begin
               freq_ff     <= prod_sat;
               oct_left_ff <= oct_left_ff - 1'b1;
               step_ff     <= '0;
               state_ff    <= (oct_left_ff == fgn_pkg::OCT_W'(1)) ? ST_DIV : ST_POS;
            end
            ST_DIV: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  n_ff     <= div_n;
                  state_ff <= ST_HEIGHT_MUL;
               end
            end
            ST_HEIGHT_MUL: state_ff <= ST_HEIGHT_TAKE;
            ST_HEIGHT_TAKE: begin
               rsp_height_ff <= h_sat;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = rsp_height_ff;

endmodule

FILE: rtl/fgn_checker.sv
`timescale 1ns / 1ps

module fgn_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_valid
);

   // an evaluate transfer always occupies the unit
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == fgn_pkg::OP_EVAL |=> busy)
      else $error("evaluate transfer did not raise busy");

   // table loads leave the unit idle and give no result
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == fgn_pkg::OP_WRITE |=> !busy && !rsp_valid)
      else $error("table write produced activity");

   // result appears exactly when the unit goes idle
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind fractal_gradient_noise_unit fgn_checker u_fgn_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid)
);

FILE: dv/tb_fractal_gradient_noise_unit.sv
`timescale 1ns / 1ps

// Testbench for fractal_gradient_noise_unit.
// A predictor inside the bench evaluates the same octave sum from its own copy
// of the permutation table and the CSRs and queues one expected height for each
// accepted evaluate. A checker compares every rsp_valid strobe with the oldest
// queued height. The stimulus runs in named phases: reset defaults,
//   directed corners, table shuffles, random CSR phases, and a final phase
//   without idle gaps. CSRs are only touched after the unit has gone quiet.
module tb_fractal_gradient_noise_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 900;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_opcode;
   logic signed [31:0]           req_pos_x;
   logic signed [31:0]           req_pos_y;
   logic signed [31:0]           req_pos_z;
   logic [7:0]                   req_table_index;
   logic [7:0]                   req_table_value;
   logic                         rsp_valid;
   logic signed [31:0]           rsp_height;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [fgn_pkg::CSR_AW-1:0]   csr_index;
   logic [31:0]                  csr_wdata;

   fractal_gradient_noise_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .rsp_valid       (rsp_valid),
      .rsp_height      (rsp_height),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Shadow copy of the unit's state
   bit [31:0]  sh_base_freq;
   bit [4:0]   sh_octaves;
   bit [19:0]  sh_amp_factor;
   bit [19:0]  sh_freq_factor;
   longint     sh_height_low;
   longint     sh_height_high;
   bit [7:0]   sh_perm [fgn_pkg::PERM_ENTRIES];

   logic signed [31:0] height_q [$];

   int  errors;
   int  eval_count;
   int  write_count;
   int  csr_count;
   int  height_count;
   int  quiet_cycles;
   bit  calm;          // no idle gaps while set

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint perm_at(int unsigned i);
      return longint'(sh_perm[i & 255]);
   endfunction

   // fade curve 6t^5 - 15t^4 + 10t^3 in Q16, each factor floored
   function automatic longint fade_curve(longint t);
      longint cube;
      longint poly;
      cube = (t * t * t) >>> 32;
      poly = ((6 * t * t) >>> 16) + 10 * 65536 - 15 * t;
      return (cube * poly) >>> 16;
   endfunction

   function automatic longint mix(longint t, longint a, longint b);
      return a + ((t * (b - a)) >>> 16);   // arithmetic shift is a floor
   endfunction

   function automatic longint edge_dot(longint hash, longint x, longint y, longint z);
      int unsigned h;
      longint u;
      longint v;
      h = int'(hash) & 15;
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      if (h & 1) u = -u;
      if (h & 2) v = -v;
      return u + v;
   endfunction

   // One octave of gradient noise, Q1.15
   function automatic longint octave_value(bit [63:0] sx, bit [63:0] sy, bit [63:0] sz,
                                           bit [31:0] freq);
      bit [63:0] px, py, pz;
      int unsigned cx, cy, cz, a, aa, ab, b, ba, bb;
      longint x0, y0, z0, x1, y1, z1, u, v, w, n0, n1, n;
      px = sx * {32'd0, freq};
      py = sy * {32'd0, freq};
      pz = sz * {32'd0, freq};
      cx = px[31:24];
      cy = py[31:24];
      cz = pz[31:24];
      x0 = longint'(px[23:8]);
      y0 = longint'(py[23:8]);
      z0 = longint'(pz[23:8]);
      x1 = x0 - 65536;
      y1 = y0 - 65536;
      z1 = z0 - 65536;
      u = fade_curve(x0);
      v = fade_curve(y0);
      w = fade_curve(z0);
      a  = int'(perm_at(cx)) + cy;
      aa = int'(perm_at(a)) + cz;
      ab = int'(perm_at(a + 1)) + cz;
      b  = int'(perm_at(cx + 1)) + cy;
      ba = int'(perm_at(b)) + cz;
      bb = int'(perm_at(b + 1)) + cz;
      n0 = mix(v, mix(u, edge_dot(perm_at(aa), x0, y0, z0), edge_dot(perm_at(ba), x1, y0, z0)),
                  mix(u, edge_dot(perm_at(ab), x0, y1, z0), edge_dot(perm_at(bb), x1, y1, z0)));
      n1 = mix(v, mix(u, edge_dot(perm_at(aa + 1), x0, y0, z1),
                         edge_dot(perm_at(ba + 1), x1, y0, z1)),
                  mix(u, edge_dot(perm_at(ab + 1), x0, y1, z1),
                         edge_dot(perm_at(bb + 1), x1, y1, z1)));
      n = mix(w, n0, n1) >>> 1;
      if (n > 32767) n = 32767;
      if (n < -32768) n = -32768;
      return n;
   endfunction

   function automatic logic signed [31:0] predict_height(logic signed [31:0] x,
                                                        logic signed [31:0] y,
                                                        logic signed [31:0] z);
      bit [63:0] sx, sy, sz, freq, amp;
      int unsigned count;
      longint total, amp_sum, n, h;
      sx = {{32{x[31]}}, x};
      sy = {{32{y[31]}}, y};
      sz = {{32{z[31]}}, z};
      count = (sh_octaves > fgn_pkg::MAX_OCTAVES) ? fgn_pkg::MAX_OCTAVES : sh_octaves;
      n = 0;
      if (count > 0) begin
         total   = 0;
         amp_sum = 0;
         freq    = {32'd0, sh_base_freq};
         amp     = 64'd65536;
         for (int k = 0; k < count; k++) begin
            total   += octave_value(sx, sy, sz, freq[31:0]) * longint'(amp);
            amp_sum += longint'(amp);
            amp  = (amp * sh_amp_factor) >> 16;
            if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
            freq = (freq * sh_freq_factor) >> 16;
            if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
         end
         if (amp_sum > 0) n = total / amp_sum;   // truncates toward zero
         if (n > 32767) n = 32767;
         if (n < -32768) n = -32768;
      end
      h = sh_height_low + (((n + 32768) * (sh_height_high - sh_height_low)) >>> 16);
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return h[31:0];
   endfunction

   // ------------------------------------------------------------------ checker

   task automatic report_mismatch(string what, logic signed [31:0] want,
                                  logic signed [31:0] got);
      errors++;
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         height_count++;
         if (height_q.size() == 0) begin
            report_mismatch("unexpected height", 0, rsp_height);
         end else begin
            logic signed [31:0] want;
            want = height_q.pop_front();
            if (rsp_height !== want) report_mismatch("height", want, rsp_height);
         end
      end
   end

   // Watchdog: cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d heights outstanding", height_q.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Leaves start high after the transfer; an idle gap or wait_quiet lowers it.
   task automatic send_item(logic op, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic [7:0] idx, logic [7:0] val);
      start           <= 1'b1;
      req_opcode      <= op;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_pos_z       <= z;
      req_table_index <= idx;
      req_table_value <= val;
      do @(posedge clock); while (busy);
      if (op == fgn_pkg::OP_WRITE) begin
         sh_perm[idx] = val;
         write_count++;
      end else begin
         height_q.push_back(predict_height(x, y, z));
         eval_count++;
      end
   endtask

   task automatic idle_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (height_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [fgn_pkg::CSR_AW-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         fgn_pkg::REG_BASE_FREQ:   sh_base_freq   = data;
         fgn_pkg::REG_OCT_COUNT:   sh_octaves     = data[4:0];
         fgn_pkg::REG_AMP_FACTOR:  sh_amp_factor  = data[19:0];
         fgn_pkg::REG_FREQ_FACTOR: sh_freq_factor = data[19:0];
         fgn_pkg::REG_HEIGHT_LOW:  sh_height_low  = longint'(signed'(data));
         fgn_pkg::REG_HEIGHT_HIGH: sh_height_high = longint'(signed'(data));
         default: ;
      endcase
      csr_count++;
      @(posedge clock);
   endtask

   task automatic set_all(logic [31:0] bf, logic [31:0] oc, logic [31:0] af,
                          logic [31:0] ff, logic [31:0] hl, logic [31:0] hh);
      wait_quiet();
      write_csr(fgn_pkg::REG_BASE_FREQ, bf);
      write_csr(fgn_pkg::REG_OCT_COUNT, oc);
      write_csr(fgn_pkg::REG_AMP_FACTOR, af);
      write_csr(fgn_pkg::REG_FREQ_FACTOR, ff);
      write_csr(fgn_pkg::REG_HEIGHT_LOW, hl);
      write_csr(fgn_pkg::REG_HEIGHT_HIGH, hh);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 4000)) - 2000;
         2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $signed($urandom_range(0, 200)) - 100;
      endcase
   endfunction

   task automatic send_random();
      if ($urandom_range(0, 99) < 15)
         send_item(fgn_pkg::OP_WRITE, $urandom, $urandom, $urandom,
                   8'($urandom), 8'($urandom));
      else
         send_item(fgn_pkg::OP_EVAL, rand_coord(), rand_coord(), rand_coord(),
                   8'($urandom), 8'($urandom));
      idle_gap();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      // defaults after reset, including the identity table
      send_item(fgn_pkg::OP_EVAL, 0, 0, 0, 0, 0);
      send_item(fgn_pkg::OP_EVAL, 1, 2, 3, 0, 0);
      send_item(fgn_pkg::OP_EVAL, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 0, 0);
      send_item(fgn_pkg::OP_EVAL, 37, -91, 12345, 0, 0);
   endtask

   task automatic test_corners();
      // zero octaves: midpoint of the range
      set_all(32'h0100_0000, 0, 32768, 131072, -10000, 10000);
      send_item(fgn_pkg::OP_EVAL, 5, 6, 7, 0, 0);
      // more octaves than supported saturate at the maximum
      set_all(32'h0040_0000, 31, 32768, 131072, -10000, 10000);
      send_item(fgn_pkg::OP_EVAL, 3, -4, 5, 0, 0);
      set_all(32'h0040_0000, fgn_pkg::MAX_OCTAVES + 1, 32'hFFFFF, 32'hFFFFF, -5, 5);
      send_item(fgn_pkg::OP_EVAL, -3, 4, 9, 0, 0);
      // full-scale range, reversed range, frequency and factors at the ends
      set_all(32'hFFFF_FFFF, 3, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(fgn_pkg::OP_EVAL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
      send_item(fgn_pkg::OP_EVAL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
      set_all(0, 2, 32'hFFFFF, 32'hFFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(fgn_pkg::OP_EVAL, 1, 1, 1, 0, 0);
      set_all(32'h00A0_0000, 4, 40000, 140000, 50000, -50000);
      send_item(fgn_pkg::OP_EVAL, 11, 22, 33, 0, 0);
      send_item(fgn_pkg::OP_EVAL, -11, -22, -33, 0, 0);
      // table writes at both ends, then an evaluate that reads them
      send_item(fgn_pkg::OP_WRITE, 0, 0, 0, 8'd0, 8'd255);
      send_item(fgn_pkg::OP_WRITE, 0, 0, 0, 8'd255, 8'd0);
      send_item(fgn_pkg::OP_WRITE, 0, 0, 0, 8'd1, 8'd170);
      send_item(fgn_pkg::OP_EVAL, 0, 0, 0, 0, 0);
      send_item(fgn_pkg::OP_EVAL, 255, 255, 255, 0, 0);
   endtask

   task automatic test_table_shuffle();
      int order [fgn_pkg::PERM_ENTRIES];
      foreach (order[i]) order[i] = i;
      order.shuffle();
      calm = 1'b0;
      foreach (order[i]) begin
         send_item(fgn_pkg::OP_WRITE, $urandom, $urandom, $urandom, i[7:0], order[i][7:0]);
         idle_gap();
      end
      repeat (40) send_random();
   endtask

   task automatic test_random_phases(int budget);
      int sent;
      int n;
      logic [31:0] oc;
      logic [31:0] bf;
      sent = 0;
      while (sent < budget) begin
         oc = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 31);
         bf = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0400_0000);
         set_all(bf, oc, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                 $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 100000),
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100000));
         n = (oc > 4) ? 20 : 120;
         calm = ($urandom_range(0, 3) == 0);
         repeat (n) send_random();
         sent += n;
      end
   endtask

   task automatic test_back_to_back();
      set_all(32'h0080_0000, 2, 32768, 131072, -10000, 10000);
      calm = 1'b1;
      repeat (100) send_random();
   endtask

   initial begin
      eval_count   = 0;
      write_count  = 0;
      csr_count    = 0;
      calm         = 1'b1;
      sh_base_freq   = 32'h0100_0000;
      sh_octaves     = 5'd1;
      sh_amp_factor  = 20'd32768;
      sh_freq_factor = 20'd131072;
      sh_height_low  = -10000;
      sh_height_high = 10000;
      foreach (sh_perm[i]) sh_perm[i] = i[7:0];

      reset           <= 1'b1;
      start           <= 1'b0;
      req_opcode      <= fgn_pkg::OP_EVAL;
      req_pos_x       <= '0;
      req_pos_y       <= '0;
      req_pos_z       <= '0;
      req_table_index <= '0;
      req_table_value <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_corners();
      test_table_shuffle();
      test_random_phases(1500);
      test_back_to_back();

      start <= 1'b0;
      @(posedge clock);
      while (height_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d evaluates, %0d table writes, %0d CSR writes",
               eval_count, write_count, csr_count);
      $display("checked %0d heights, %0d mismatches", height_count, errors);
      if (errors == 0 && height_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
